FILE: rtl/fslt_pkg.sv
// Shared types, codes and helpers of the free-list slot table.
`timescale 1ns / 1ps

package fslt_pkg;

  // Fixed port field widths
  localparam int NAME_W     = 64;
  localparam int VALUE_W    = 16;
  localparam int INDEX_W    = 8;
  localparam int SLOT_W     = 8;
  localparam int FREE_W     = 9;
  // Width that holds any stored link word and any terminal slot number
  localparam int LINK_CMP_W = 17;

  // Request codes
  typedef enum logic [1:0] {
    CMD_ADD  = 2'd0,
    CMD_DEL  = 2'd1,
    CMD_SRCH = 2'd2,
    CMD_NOP  = 2'd3
  } cmd_code_t;

  // Result status codes
  typedef enum logic [1:0] {
    ST_OK        = 2'd0,
    ST_FULL      = 2'd1,
    ST_BAD_INDEX = 2'd2,
    ST_NOT_FOUND = 2'd3
  } status_t;

  // Controller states
  typedef enum logic [2:0] {
    S_IDLE,
    S_ADD_CHK,
    S_ADD_POP,
    S_DEL_CHK,
    S_DEL_WR,
    S_SRCH,
    S_RESP
  } state_t;

  // Datapath operations issued by the controller
  typedef enum logic [3:0] {
    OP_NONE,
    OP_CAPTURE,
    OP_ADD_TAIL,
    OP_ADD_FULL,
    OP_ADD_POP,
    OP_DEL_BAD,
    OP_DEL_PUSH,
    OP_SCAN,
    OP_SRCH_HIT,
    OP_SRCH_MISS
  } dp_op_t;

  // Controller to datapath
  typedef struct packed {
    dp_op_t op;
    logic   load_out;
  } fslt_cmd_t;

  // Datapath to controller
  typedef struct packed {
    logic head_is_term;  // free-list head is the terminal slot
    logic full;          // table already at capacity
    logic idx_bad;       // delete index at or past the terminal
    logic hit;           // scan compare matched
    logic miss;          // scan ran out of slots
  } fslt_stat_t;

  // Keep name bytes before the first zero byte, within nbytes bytes
  function automatic logic [NAME_W-1:0] norm_name(input logic [NAME_W-1:0] n,
                                                  input int nbytes);
    logic [NAME_W-1:0] r;
    logic              stop;
    r    = '0;
    stop = 1'b0;
    for (int k = 0; k < NAME_W / 8; k++) begin
      if (k >= nbytes || n[8*k +: 8] == 8'd0) begin
        stop = 1'b1;
      end
      if (!stop) begin
        r[8*k +: 8] = n[8*k +: 8];
      end
    end
    return r;
  endfunction

endpackage

FILE: rtl/fslt_ram.sv
// Generic single-write, single-read RAM with registered read data.
`timescale 1ns / 1ps

module fslt_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 256
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write port and registered read port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

FILE: rtl/fslt_ctrl.sv
// Controller state machine of the free-list slot table.
`timescale 1ns / 1ps

module fslt_ctrl (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_ready,
  input  logic [1:0]         in_command,
  output logic               out_valid,
  input  logic               out_ready,
  input  fslt_pkg::fslt_stat_t stat,
  output fslt_pkg::fslt_cmd_t  cmd
);
  import fslt_pkg::*;

  state_t state_r, state_nxt;
  logic   out_valid_r, out_valid_nxt;
  logic   out_free;

  // Output register can take a result this cycle
  assign out_free = !out_valid_r || out_ready;

  // Next state
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          unique case (cmd_code_t'(in_command))
            CMD_ADD:  state_nxt = S_ADD_CHK;
            CMD_DEL:  state_nxt = S_DEL_CHK;
            CMD_SRCH: state_nxt = S_SRCH;
            CMD_NOP:  state_nxt = S_RESP;
          endcase
        end
      end
      S_ADD_CHK: state_nxt = stat.head_is_term ? S_RESP : S_ADD_POP;
      S_ADD_POP: state_nxt = S_RESP;
      S_DEL_CHK: state_nxt = stat.idx_bad ? S_RESP : S_DEL_WR;
      S_DEL_WR:  state_nxt = S_RESP;
      S_SRCH: begin
        if (stat.hit || stat.miss) begin
          state_nxt = S_RESP;
        end
      end
      S_RESP: begin
        if (out_free) begin
          state_nxt = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  // Datapath commands
  always_comb begin
    cmd.op       = OP_NONE;
    cmd.load_out = 1'b0;
    unique case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          cmd.op = OP_CAPTURE;
        end
      end
      S_ADD_CHK: begin
        if (stat.head_is_term) begin
          cmd.op = stat.full ? OP_ADD_FULL : OP_ADD_TAIL;
        end
      end
      S_ADD_POP: cmd.op = OP_ADD_POP;
      S_DEL_CHK: begin
        if (stat.idx_bad) begin
          cmd.op = OP_DEL_BAD;
        end
      end
      S_DEL_WR: cmd.op = OP_DEL_PUSH;
      S_SRCH: begin
        priority if (stat.hit) begin
          cmd.op = OP_SRCH_HIT;
        end else if (stat.miss) begin
          cmd.op = OP_SRCH_MISS;
        end else begin
          cmd.op = OP_SCAN;
        end
      end
      S_RESP: cmd.load_out = out_free;
      default: cmd.op = OP_NONE;
    endcase
  end

  // Result beat valid flag
  always_comb begin
    out_valid_nxt = out_valid_r;
    if (cmd.load_out) begin
      out_valid_nxt = 1'b1;
    end else if (out_ready) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  assign in_ready  = (state_r == S_IDLE);
  assign out_valid = out_valid_r;

  // A new result never overwrites one still waiting
  a_load_free: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.load_out |-> (!out_valid_r || out_ready))
    else $error("result loaded over a pending beat");

  // An accepted beat always leaves idle
  a_accept_leaves_idle: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && in_ready) |=> (state_r != S_IDLE))
    else $error("controller stayed idle after accepting a beat");

endmodule

FILE: rtl/fslt_dp.sv
// Datapath of the free-list slot table: slot RAMs, list pointers, scan and result.
`timescale 1ns / 1ps

module fslt_dp #(
  parameter int CAPACITY   = 256,
  parameter int NAME_BYTES = 8
) (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic [fslt_pkg::NAME_W-1:0]    in_name,
  input  logic [fslt_pkg::VALUE_W-1:0]   in_value,
  input  logic [fslt_pkg::INDEX_W-1:0]   in_index,
  input  fslt_pkg::fslt_cmd_t            cmd,
  output fslt_pkg::fslt_stat_t           stat,
  output logic [1:0]                     out_status,
  output logic [fslt_pkg::SLOT_W-1:0]    out_slot,
  output logic [fslt_pkg::FREE_W-1:0]    out_free_slots
);
  import fslt_pkg::*;

  localparam int NW  = 8 * NAME_BYTES;
  localparam int PW  = $clog2(CAPACITY);
  localparam int TLW = $clog2(CAPACITY + 1);
  localparam int XW  = (TLW > INDEX_W) ? TLW : INDEX_W;
  localparam int FW  = (TLW > FREE_W) ? TLW : FREE_W;

  // List and table state
  logic [PW-1:0]  free_head_r, free_head_nxt;
  logic [TLW-1:0] tlen_r, tlen_nxt;
  logic [TLW-1:0] fcnt_r, fcnt_nxt;

  // Captured request
  logic [NW-1:0]      name_r, name_nxt;
  logic [VALUE_W-1:0] value_r, value_nxt;
  logic [INDEX_W-1:0] index_r, index_nxt;

  // Scan pipeline
  logic [XW-1:0] scan_r, scan_nxt;
  logic          cmp_valid_r, cmp_valid_nxt;
  logic [PW-1:0] cmp_idx_r, cmp_idx_nxt;

  // Result and output register
  status_t             res_status_r, res_status_nxt;
  logic [SLOT_W-1:0]   res_slot_r, res_slot_nxt;
  status_t             out_status_r;
  logic [SLOT_W-1:0]   out_slot_r;
  logic [FREE_W-1:0]   out_free_r;

  // RAM ports
  logic               ram_we;
  logic [PW-1:0]      ram_waddr;
  logic [NW-1:0]      name_wdata;
  logic [VALUE_W-1:0] word_wdata;
  logic [PW-1:0]      name_raddr;
  logic [NW-1:0]      name_rdata;
  logic [VALUE_W-1:0] word_rdata;

  // Derived values
  logic [TLW-1:0]        term;
  logic [XW-1:0]         term_x, tlen_x, head_x, index_x, cmpidx_x;
  logic [NW-1:0]         cmp_name;
  logic [LINK_CMP_W-1:0] link_x, term_l, link_clamp;
  logic [NAME_W-1:0]     in_name_norm;
  logic [FW-1:0]         fcnt_f;

  fslt_ram #(.WIDTH(NW), .DEPTH(CAPACITY)) u_name_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (name_wdata),
    .raddr (name_raddr),
    .rdata (name_rdata)
  );

  fslt_ram #(.WIDTH(VALUE_W), .DEPTH(CAPACITY)) u_word_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (word_wdata),
    .raddr (free_head_r),
    .rdata (word_rdata)
  );

  // Common compare operands
  assign term     = tlen_r - TLW'(1);
  assign term_x   = XW'(term);
  assign tlen_x   = XW'(tlen_r);
  assign head_x   = XW'(free_head_r);
  assign index_x  = XW'(index_r);
  assign cmpidx_x = XW'(cmp_idx_r);

  // Terminal slot always reads as an empty name
  assign cmp_name = (cmpidx_x == term_x) ? '0 : name_rdata;

  // Next-free link, clamped to the terminal
  assign link_x     = LINK_CMP_W'(word_rdata);
  assign term_l     = LINK_CMP_W'(term);
  assign link_clamp = (link_x > term_l) ? term_l : link_x;

  assign in_name_norm = norm_name(in_name, NAME_BYTES);

  // Name RAM read address: scan pointer while scanning, else request index
  assign name_raddr = (cmd.op == OP_SCAN) ? scan_r[PW-1:0] : index_x[PW-1:0];

  // Status to controller
  always_comb begin
    stat.head_is_term = (head_x >= term_x);
    stat.full         = (tlen_r >= TLW'(CAPACITY));
    stat.idx_bad      = (index_x >= term_x);
    stat.hit          = cmp_valid_r && (cmp_name == name_r);
    stat.miss         = !cmp_valid_r && (scan_r >= tlen_x);
  end

  // Operation decode
  always_comb begin
    free_head_nxt  = free_head_r;
    tlen_nxt       = tlen_r;
    fcnt_nxt       = fcnt_r;
    name_nxt       = name_r;
    value_nxt      = value_r;
    index_nxt      = index_r;
    scan_nxt       = scan_r;
    cmp_valid_nxt  = cmp_valid_r;
    cmp_idx_nxt    = cmp_idx_r;
    res_status_nxt = res_status_r;
    res_slot_nxt   = res_slot_r;
    ram_we         = 1'b0;
    ram_waddr      = free_head_r;
    name_wdata     = name_r;
    word_wdata     = value_r;
    unique case (cmd.op)
      OP_NONE: ;
      OP_CAPTURE: begin
        name_nxt       = in_name_norm[NW-1:0];
        value_nxt      = in_value;
        index_nxt      = in_index;
        scan_nxt       = XW'(in_index);
        cmp_valid_nxt  = 1'b0;
        res_status_nxt = ST_OK;
        res_slot_nxt   = '0;
      end
      // Head is the terminal: fill it and append a new terminal
      OP_ADD_TAIL: begin
        ram_we        = 1'b1;
        ram_waddr     = term[PW-1:0];
        tlen_nxt      = tlen_r + TLW'(1);
        free_head_nxt = tlen_r[PW-1:0];
        fcnt_nxt      = TLW'(1);
        res_slot_nxt  = SLOT_W'(term);
      end
      OP_ADD_FULL: res_status_nxt = ST_FULL;
      // Pop the head, follow its link
      OP_ADD_POP: begin
        ram_we        = 1'b1;
        ram_waddr     = free_head_r;
        free_head_nxt = link_clamp[PW-1:0];
        if (fcnt_r > TLW'(1)) begin
          fcnt_nxt = fcnt_r - TLW'(1);
        end
        res_slot_nxt  = SLOT_W'(free_head_r);
      end
      OP_DEL_BAD: res_status_nxt = ST_BAD_INDEX;
      // Push an occupied slot onto the free list
      OP_DEL_PUSH: begin
        if (name_rdata[7:0] != 8'd0) begin
          ram_we        = 1'b1;
          ram_waddr     = index_x[PW-1:0];
          name_wdata    = '0;
          word_wdata    = VALUE_W'(free_head_r);
          free_head_nxt = index_x[PW-1:0];
          fcnt_nxt      = fcnt_r + TLW'(1);
        end
      end
      // Issue one slot read per cycle, compare it in the next cycle
      OP_SCAN: begin
        if (scan_r < tlen_x) begin
          cmp_valid_nxt = 1'b1;
          cmp_idx_nxt   = scan_r[PW-1:0];
          scan_nxt      = scan_r + XW'(1);
        end else begin
          cmp_valid_nxt = 1'b0;
        end
      end
      OP_SRCH_HIT:  res_slot_nxt = SLOT_W'(cmp_idx_r);
      OP_SRCH_MISS: res_status_nxt = ST_NOT_FOUND;
      default: ;
    endcase
  end

  assign fcnt_f = FW'(fcnt_r);

  // Control state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      free_head_r <= '0;
      tlen_r      <= TLW'(1);
      fcnt_r      <= TLW'(1);
      cmp_valid_r <= 1'b0;
    end else begin
      free_head_r <= free_head_nxt;
      tlen_r      <= tlen_nxt;
      fcnt_r      <= fcnt_nxt;
      cmp_valid_r <= cmp_valid_nxt;
    end
  end

  // Payload registers
  always_ff @(posedge clk) begin
    name_r       <= name_nxt;
    value_r      <= value_nxt;
    index_r      <= index_nxt;
    scan_r       <= scan_nxt;
    cmp_idx_r    <= cmp_idx_nxt;
    res_status_r <= res_status_nxt;
    res_slot_r   <= res_slot_nxt;
    if (cmd.load_out) begin
      out_status_r <= res_status_r;
      out_slot_r   <= res_slot_r;
      out_free_r   <= fcnt_f[FREE_W-1:0];
    end
  end

  assign out_status     = out_status_r;
  assign out_slot       = out_slot_r;
  assign out_free_slots = out_free_r;

  // Free count stays within the table
  a_fcnt_range: assert property (@(posedge clk) disable iff (!rst_n)
    (fcnt_r >= TLW'(1)) && (fcnt_r <= tlen_r))
    else $error("free count out of range");

  // Free-list head always inside the table
  a_head_in_table: assert property (@(posedge clk) disable iff (!rst_n)
    head_x < tlen_x)
    else $error("free-list head past terminal");

  // Table only grows, one slot at a time
  a_tlen_step: assert property (@(posedge clk) disable iff (!rst_n)
    ($past(rst_n) && (tlen_r != $past(tlen_r))) |-> (tlen_r == $past(tlen_r) + TLW'(1)))
    else $error("table length changed by other than one");

endmodule

FILE: rtl/free_list_slot_table.sv
// Top level of the free-list slot table: controller plus datapath.
`timescale 1ns / 1ps

// Table of named slots with a free list threaded through the value words and a
// terminal free slot at the end. One request is in flight at a time; a finished
// result sits in an output register so the next request can be taken while it
// waits. Add goes from a check state to the result (terminal fill or full) or via
// a pop state (pop from the free list, one RAM read of the link word). Delete goes
// from a check state to the result for a bad index, else via a write state (one
// RAM read of the slot name). Search scans one slot per cycle from the request
// index up to the table length through the single read port of the name RAM.
// The slot RAMs need no clearing after reset: only written slots are ever read,
// and the terminal slot reads as an empty name by construction.
module free_list_slot_table #(
  parameter int CAPACITY   = 256,
  parameter int NAME_BYTES = 8
) (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         in_valid,
  output logic                         in_ready,
  input  logic [1:0]                   in_command,
  input  logic [fslt_pkg::NAME_W-1:0]  in_name,
  input  logic [fslt_pkg::VALUE_W-1:0] in_value,
  input  logic [fslt_pkg::INDEX_W-1:0] in_index,
  output logic                         out_valid,
  input  logic                         out_ready,
  output logic [1:0]                   out_status,
  output logic [fslt_pkg::SLOT_W-1:0]  out_slot,
  output logic [fslt_pkg::FREE_W-1:0]  out_free_slots
);
  import fslt_pkg::*;

  fslt_cmd_t  cmd;
  fslt_stat_t stat;

  fslt_ctrl u_ctrl (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (in_valid),
    .in_ready   (in_ready),
    .in_command (in_command),
    .out_valid  (out_valid),
    .out_ready  (out_ready),
    .stat       (stat),
    .cmd        (cmd)
  );

  fslt_dp #(
    .CAPACITY   (CAPACITY),
    .NAME_BYTES (NAME_BYTES)
  ) u_dp (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_name        (in_name),
    .in_value       (in_value),
    .in_index       (in_index),
    .cmd            (cmd),
    .stat           (stat),
    .out_status     (out_status),
    .out_slot       (out_slot),
    .out_free_slots (out_free_slots)
  );

endmodule
